>>> rtl/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg: shared types and constants of the quadratic probe hash table
// Operation and status codes, field widths and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qpht_pkg;

	// Fixed field widths.
	localparam int KEY_W  = 31;
	localparam int PAY_W  = 32;
	localparam int SIZE_W = 7;
	localparam int SLOT_W = 6;

	// Table size register after reset.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// The home slot divider retires two key bits per step.
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    div_step;
		logic    probe_init;
		logic    probe_adv;
		logic    mem_rd;
		logic    wr_clear;
		logic    wr_insert;
		logic    wr_delete;
		logic    res_load;
		status_t res_status;
		logic    res_slot;
		logic    res_pay;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic sweep_last;
		logic probe_last;
		logic rd_occ;
		logic rd_del;
		logic key_hit;
	} stat_t;

endpackage

>>> rtl/qpht_dp.sv
// ----------------------------------------------------------------------------
// qpht_dp: datapath of the quadratic probe hash table
// Holds the size register, the home slot divider, the probe sequence,
// the slot memory and the result register.
// ----------------------------------------------------------------------------
module qpht_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_PROBES  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0]         cfg_wdata,
	input  logic [qpht_pkg::KEY_W-1:0]          key,
	input  logic [qpht_pkg::PAY_W-1:0]          payload_in,
	input  qpht_pkg::cmd_t                      cmd,
	output qpht_pkg::stat_t                     stat,
	output logic [1:0]                          status,
	output logic [qpht_pkg::SLOT_W-1:0]         slot,
	output logic [qpht_pkg::PAY_W-1:0]          payload_out
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = $clog2(MAX_PROBES + 1);
	localparam int SW = qpht_pkg::SIZE_W;
	localparam int KW = qpht_pkg::KEY_W;
	localparam int PW = qpht_pkg::PAY_W;
	localparam int CW = qpht_pkg::DIV_CNT_W;

	typedef struct packed {
		logic [KW-1:0] key;
		logic [PW-1:0] pay;
		logic          occ;
		logic          del;
	} entry_t;

	logic [SW-1:0] size_cfg_q;
	logic [SW-1:0] size_eff;
	logic [SW-1:0] size_q;
	logic [SW-1:0] dvsr_q;
	logic [KW-1:0] key_q;
	logic [PW-1:0] pay_q;
	logic [KW:0]   key_sh_q;
	logic [SW-1:0] rem_q;
	logic [SW:0]   r1;
	logic [SW:0]   r2;
	logic [CW-1:0] div_cnt_q;
	logic [SW-1:0] p_q;
	logic [SW-1:0] inc_q;
	logic [SW:0]   psum;
	logic [SW:0]   isum;
	logic [IW-1:0] i_q;
	logic [AW-1:0] sw_q;
	logic          sweep_last;
	logic [AW-1:0] wr_addr;
	logic          mem_we;
	entry_t        wr_word;
	entry_t        mem [TABLE_DEPTH];
	entry_t        rd_q;

	qpht_pkg::status_t             out_status_q;
	logic [qpht_pkg::SLOT_W-1:0]   out_slot_q;
	logic [PW-1:0]                 out_pay_q;

	// Clamp the configured size to at least 2 and at most the slots that exist.
	always_comb begin
		size_eff = size_cfg_q;
		if (size_cfg_q < SW'(2)) begin
			size_eff = SW'(2);
		end else if (32'(size_cfg_q) > TABLE_DEPTH) begin
			size_eff = SW'(TABLE_DEPTH);
		end
	end

	// Size register and clearing sweep pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= qpht_pkg::SIZE_RESET;
			sw_q       <= '0;
		end else begin
			if (cfg_we) begin
				size_cfg_q <= cfg_wdata;
			end
			if (cmd.latch) begin
				sw_q <= '0;
			end else if (cmd.wr_clear) begin
				sw_q <= sweep_last ? '0 : sw_q + AW'(1);
			end
		end
	end

	assign sweep_last = (sw_q == AW'(TABLE_DEPTH - 1));

	// Two restoring remainder steps per cycle: key mod (size - 1).
	always_comb begin
		r1 = {rem_q, key_sh_q[KW]};
		if (r1 >= {1'b0, dvsr_q}) begin
			r1 = r1 - {1'b0, dvsr_q};
		end
		r2 = {r1[SW-1:0], key_sh_q[KW-1]};
		if (r2 >= {1'b0, dvsr_q}) begin
			r2 = r2 - {1'b0, dvsr_q};
		end
	end

	// Next probe: p += 2i+1 and the step grows by two, both mod size.
	always_comb begin
		psum = {1'b0, p_q} + {1'b0, inc_q};
		if (psum >= {1'b0, size_q}) begin
			psum = psum - {1'b0, size_q};
		end
		isum = {1'b0, inc_q} + (SW + 1)'(2);
		if (isum >= {1'b0, size_q}) begin
			isum = isum - {1'b0, size_q};
		end
	end

	// Operand capture, divider and probe sequence registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			key_q     <= key;
			pay_q     <= payload_in;
			key_sh_q  <= {1'b0, key};
			rem_q     <= '0;
			div_cnt_q <= '0;
			size_q    <= size_eff;
			dvsr_q    <= size_eff - SW'(1);
		end else if (cmd.div_step) begin
			key_sh_q  <= {key_sh_q[KW-2:0], 2'b00};
			rem_q     <= r2[SW-1:0];
			div_cnt_q <= div_cnt_q + CW'(1);
		end
		if (cmd.probe_init) begin
			p_q   <= rem_q;
			inc_q <= SW'(1);
			i_q   <= '0;
		end else if (cmd.probe_adv) begin
			p_q   <= psum[SW-1:0];
			inc_q <= isum[SW-1:0];
			i_q   <= i_q + IW'(1);
		end
	end

	// Slot memory write selection.
	always_comb begin
		mem_we  = cmd.wr_clear | cmd.wr_insert | cmd.wr_delete;
		wr_addr = cmd.wr_clear ? sw_q : AW'(p_q);
		wr_word = '0;
		priority if (cmd.wr_insert) begin
			wr_word = '{key: key_q, pay: pay_q, occ: 1'b1, del: 1'b0};
		end else if (cmd.wr_delete) begin
			wr_word = '{key: rd_q.key, pay: rd_q.pay, occ: 1'b1, del: 1'b1};
		end else begin
			wr_word = '0;
		end
	end

	// Slot memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_word;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[AW'(p_q)];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_slot_q   <= cmd.res_slot ? p_q[qpht_pkg::SLOT_W-1:0] : '0;
			out_pay_q    <= cmd.res_pay ? rd_q.pay : '0;
		end
	end

	assign status      = out_status_q;
	assign slot        = out_slot_q;
	assign payload_out = out_pay_q;

	// Status back to the controller.
	assign stat.div_last   = (div_cnt_q == CW'(qpht_pkg::DIV_STEPS - 1));
	assign stat.sweep_last = sweep_last;
	assign stat.probe_last = (i_q == IW'(MAX_PROBES - 1));
	assign stat.rd_occ     = rd_q.occ;
	assign stat.rd_del     = rd_q.del;
	assign stat.key_hit    = (rd_q.key == key_q);

endmodule

>>> rtl/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl: controller of the quadratic probe hash table
// Sequences the clearing sweep, the home slot division and the probe
// loop, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module qpht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	output logic              out_valid,
	input  logic              out_ready,
	input  qpht_pkg::stat_t   stat,
	output qpht_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_CLR_END,
		S_DIV,
		S_HOME,
		S_RD,
		S_CHK
	} state_t;

	state_t           state_q;
	qpht_pkg::op_t    op_q;
	logic             out_valid_q;
	logic             out_free;
	logic             fin;
	logic             adv;
	logic             fin_ins;
	logic             fin_del;
	logic             fin_slot;
	logic             fin_pay;
	qpht_pkg::status_t fin_status;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Outcome of the probe whose slot word has just been read.
	always_comb begin
		fin        = 1'b0;
		adv        = 1'b0;
		fin_ins    = 1'b0;
		fin_del    = 1'b0;
		fin_slot   = 1'b0;
		fin_pay    = 1'b0;
		fin_status = qpht_pkg::ST_MISS;
		if (op_q == qpht_pkg::OP_INSERT) begin
			priority if (!stat.rd_occ) begin
				fin        = 1'b1;
				fin_ins    = 1'b1;
				fin_slot   = 1'b1;
				fin_status = qpht_pkg::ST_OK;
			end else if (stat.probe_last) begin
				fin        = 1'b1;
				fin_status = qpht_pkg::ST_FULL;
			end else begin
				adv = 1'b1;
			end
		end else begin
			priority if (!stat.rd_occ) begin
				fin = 1'b1;
			end else if (stat.key_hit) begin
				fin = 1'b1;
				if (op_q == qpht_pkg::OP_DELETE) begin
					fin_del    = 1'b1;
					fin_slot   = 1'b1;
					fin_status = qpht_pkg::ST_OK;
				end else if (!stat.rd_del) begin
					fin_slot   = 1'b1;
					fin_pay    = 1'b1;
					fin_status = qpht_pkg::ST_OK;
				end
			end else if (stat.probe_last) begin
				fin = 1'b1;
			end else begin
				adv = 1'b1;
			end
		end
	end

	// Command decode.
	always_comb begin
		cmd            = '0;
		cmd.res_status = qpht_pkg::ST_OK;
		unique case (state_q)
			S_INIT: begin
				cmd.wr_clear = 1'b1;
			end
			S_IDLE: begin
				cmd.latch = in_valid;
			end
			S_CLR: begin
				cmd.wr_clear = 1'b1;
			end
			S_CLR_END: begin
				cmd.res_load = out_free;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_HOME: begin
				cmd.probe_init = 1'b1;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
			end
			S_CHK: begin
				cmd.probe_adv = adv;
				if (fin && out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = fin_status;
					cmd.res_slot   = fin_slot;
					cmd.res_pay    = fin_pay;
					cmd.wr_insert  = fin_ins;
					cmd.wr_delete  = fin_del;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			op_q        <= qpht_pkg::OP_INSERT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (stat.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= qpht_pkg::op_t'(op);
						state_q <= (op == qpht_pkg::OP_CLEAR) ? S_CLR : S_DIV;
					end
				end
				S_CLR: begin
					if (stat.sweep_last) begin
						state_q <= S_CLR_END;
					end
				end
				S_CLR_END: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_HOME;
					end
				end
				S_HOME: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (adv) begin
						state_q <= S_RD;
					end else if (fin && out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// A result is loaded only into a free output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result loaded while output word still waiting");

	// At most one memory write source at a time.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_clear, cmd.wr_insert, cmd.wr_delete}))
		else $error("conflicting slot memory writes");

	// Table full is only reported for an insert.
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load && cmd.res_status == qpht_pkg::ST_FULL)
		|-> (op_q == qpht_pkg::OP_INSERT))
		else $error("table full reported for a non-insert operation");

	// One operation at a time.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted while an operation runs");

	// A loaded result is presented on the next cycle.
	a_valid_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

>>> rtl/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressed key/payload table
// Insert, find, delete-mark and clear with quadratic probing from the
// home slot key mod (size - 1).
// ----------------------------------------------------------------------------
//
// Channel   Signals                          Direction  Word
// in        in_valid/in_ready                sink       op, key, payload_in
// out       out_valid/out_ready              source     status, slot, payload_out
// cfg       cfg_we                           sink       cfg_wdata (table size)
//
// Insert, find and delete run the home slot divider at two key bits per step,
// then a home step, then a read and a check step for each slot probed. Clear
// writes one memory row per cycle. After reset a clearing pass runs before
// the first word is accepted. A new word is accepted while a result waits;
// an operation stalls at its end until that result has been taken.
//
module quadratic_probe_hash_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_PROBES  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      op,
	input  logic [qpht_pkg::KEY_W-1:0]      key,
	input  logic [qpht_pkg::PAY_W-1:0]      payload_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [qpht_pkg::SLOT_W-1:0]     slot,
	output logic [qpht_pkg::PAY_W-1:0]      payload_out
);

	qpht_pkg::cmd_t  cmd;
	qpht_pkg::stat_t stat;

	// Sequencing and handshakes.
	qpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic, slot memory and result register.
	qpht_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_PROBES  (MAX_PROBES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.key         (key),
		.payload_in  (payload_in),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.slot        (slot),
		.payload_out (payload_out)
	);

endmodule

>>> tb/hash_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_checker: result checker for the quadratic probe hash table
// Watches the configuration port and both channels. It keeps its own copy of
// the table and the size register, and it works out the reply for every word
// that is accepted on the input channel. Each reply word taken on the output
// channel is compared field by field with the oldest pending reply.
// ----------------------------------------------------------------------------
module hash_table_checker #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_PROBES  = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [qpht_pkg::KEY_W-1:0]  key,
	input  logic [qpht_pkg::PAY_W-1:0]  payload_in,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  status,
	input  logic [qpht_pkg::SLOT_W-1:0] slot,
	input  logic [qpht_pkg::PAY_W-1:0]  payload_out,
	output int unsigned                 fail_count,
	output int unsigned                 outstanding
);

	typedef struct packed {
		qpht_pkg::status_t           st;
		logic [qpht_pkg::SLOT_W-1:0] slot_no;
		logic [qpht_pkg::PAY_W-1:0]  pay;
	} table_reply_t;

	// Shadow copy of the table and of the size register.
	logic [qpht_pkg::KEY_W-1:0]  stored_key [TABLE_DEPTH];
	logic [qpht_pkg::PAY_W-1:0]  stored_pay [TABLE_DEPTH];
	logic                        occupied   [TABLE_DEPTH];
	logic                        tombstone  [TABLE_DEPTH];
	logic [qpht_pkg::SIZE_W-1:0] size_reg;

	// Replies still owed by the block, oldest first.
	table_reply_t pending_replies[$];

	// Prints one line per mismatch and counts it.
	task automatic log_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// Applies one operation to the shadow table and returns the reply word.
	function automatic table_reply_t table_op_outcome(input qpht_pkg::op_t oper,
		input logic [qpht_pkg::KEY_W-1:0] k, input logic [qpht_pkg::PAY_W-1:0] p);
		table_reply_t r;
		int unsigned  span;
		int unsigned  home;
		int unsigned  idx;
		int           n;
		r.st      = qpht_pkg::ST_MISS;
		r.slot_no = '0;
		r.pay     = '0;
		// Sizes outside the legal range are clamped.
		span = size_reg;
		if (span < 2)
			span = 2;
		if (span > TABLE_DEPTH)
			span = TABLE_DEPTH;
		home = {1'b0, k} % (span - 1);
		case (oper)
			qpht_pkg::OP_CLEAR: begin
				for (n = 0; n < TABLE_DEPTH; n++) begin
					occupied[n]  = 1'b0;
					tombstone[n] = 1'b0;
				end
				r.st = qpht_pkg::ST_OK;
			end
			qpht_pkg::OP_INSERT: begin
				// Deleted slots stay occupied, so only never-used slots are taken.
				r.st = qpht_pkg::ST_FULL;
				for (n = 0; n < MAX_PROBES; n++) begin
					idx = (home + n * n) % span;
					if (!occupied[idx]) begin
						stored_key[idx] = k;
						stored_pay[idx] = p;
						occupied[idx]   = 1'b1;
						tombstone[idx]  = 1'b0;
						r.st            = qpht_pkg::ST_OK;
						r.slot_no       = idx[qpht_pkg::SLOT_W-1:0];
						break;
					end
				end
			end
			default: begin
				// Find and delete stop at a free slot or at the first key match.
				for (n = 0; n < MAX_PROBES; n++) begin
					idx = (home + n * n) % span;
					if (!occupied[idx])
						break;
					if (stored_key[idx] == k) begin
						if (oper == qpht_pkg::OP_DELETE) begin
							tombstone[idx] = 1'b1;
							r.st           = qpht_pkg::ST_OK;
							r.slot_no      = idx[qpht_pkg::SLOT_W-1:0];
						end else if (!tombstone[idx]) begin
							r.st      = qpht_pkg::ST_OK;
							r.slot_no = idx[qpht_pkg::SLOT_W-1:0];
							r.pay     = stored_pay[idx];
						end
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Track configuration writes, check reply words, predict new ones.
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		if (!arst_n) begin
			for (int n = 0; n < TABLE_DEPTH; n++) begin
				stored_key[n] = '0;
				stored_pay[n] = '0;
				occupied[n]   = 1'b0;
				tombstone[n]  = 1'b0;
			end
			size_reg = qpht_pkg::SIZE_RESET;
			pending_replies.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				size_reg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					log_mismatch("reply word with no operation pending");
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.st)
						log_mismatch($sformatf("status got %0d want %0d", status, want.st));
					if (slot !== want.slot_no)
						log_mismatch($sformatf("slot got %0d want %0d", slot, want.slot_no));
					if (payload_out !== want.pay)
						log_mismatch($sformatf("payload_out got %h want %h",
							payload_out, want.pay));
				end
			end
			if (in_valid && in_ready)
				pending_replies.push_back(
					table_op_outcome(qpht_pkg::op_t'(op), key, payload_in));
			outstanding <= pending_replies.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the quadratic probe hash table
// A directed sequence covers full tables, spent probe budgets, deleted
// matches, repeated keys, clear and clamped sizes. Then random phases, each
// at a given table size, run keys drawn from a small pool so that finds and
// deletes hit. Both channels idle at random; the receiver also holds off once
// for a long stretch. The checker instance does all prediction and checking.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH  = 64;
	localparam int PROBES = 64;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [qpht_pkg::SIZE_W-1:0] cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic [1:0]                  op;
	logic [qpht_pkg::KEY_W-1:0]  key;
	logic [qpht_pkg::PAY_W-1:0]  payload_in;
	logic                        out_valid;
	logic                        out_ready;
	logic [1:0]                  status;
	logic [qpht_pkg::SLOT_W-1:0] slot;
	logic [qpht_pkg::PAY_W-1:0]  payload_out;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned words_sent;
	logic        steady;
	logic        squeeze;
	logic        squeezed;
	int unsigned hold_left;

	quadratic_probe_hash_table #(
		.TABLE_DEPTH(DEPTH),
		.MAX_PROBES (PROBES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.payload_in (payload_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.payload_out(payload_out)
	);

	hash_table_checker #(
		.TABLE_DEPTH(DEPTH),
		.MAX_PROBES (PROBES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.payload_in (payload_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.payload_out(payload_out),
		.fail_count (mismatches),
		.outstanding(outstanding)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Reply side: random stalls, none during the steady stretch, and one long
	// hold-off so that the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			squeezed  <= 1'b0;
		end else if (squeeze && !squeezed) begin
			squeezed  <= 1'b1;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= 29);
		end
	end

	// Offers one word, with a random gap in front, and waits until it is taken.
	task automatic send_word(input qpht_pkg::op_t oper, input logic [qpht_pkg::KEY_W-1:0] k,
		input logic [qpht_pkg::PAY_W-1:0] p);
		steady = (words_sent >= 450) && (words_sent < 650);
		if (!steady) begin
			while ($urandom_range(0, 99) < 29) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		op         <= oper;
		key        <= k;
		payload_in <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// Lets every pending reply drain, then writes the size register.
	task automatic set_table_size(input logic [qpht_pkg::SIZE_W-1:0] size_val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= size_val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random phase at a given size, keys mostly from a small pool.
	task automatic random_phase(input logic [qpht_pkg::SIZE_W-1:0] size_val,
		input int count);
		logic [qpht_pkg::KEY_W-1:0] pool[$];
		logic [qpht_pkg::KEY_W-1:0] k;
		qpht_pkg::op_t              oper;
		int                         pool_n;
		int                         r;
		set_table_size(size_val);
		pool_n = $urandom_range(2, ((size_val > 64) ? 64 : size_val) + 6);
		repeat (pool_n) begin
			if ($urandom_range(0, 3) == 0)
				pool.push_back(qpht_pkg::KEY_W'($urandom_range(0, 300)));
			else
				pool.push_back(qpht_pkg::KEY_W'($urandom()));
		end
		repeat (count) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 82)
				k = pool[$urandom_range(0, pool.size() - 1)];
			else
				k = qpht_pkg::KEY_W'($urandom());
			if (r < 42) begin
				oper = qpht_pkg::OP_INSERT;
			end else if (r < 72) begin
				oper = qpht_pkg::OP_FIND;
			end else if (r < 90) begin
				oper = qpht_pkg::OP_DELETE;
			end else if (r < 93) begin
				oper = qpht_pkg::OP_CLEAR;
			end else begin
				// Lookups of keys that are almost surely absent.
				oper = qpht_pkg::OP_FIND;
				k    = qpht_pkg::KEY_W'($urandom());
			end
			if (words_sent == 800)
				squeeze <= 1'b1;
			send_word(oper, k, $urandom());
		end
	endtask

	// Main stimulus and verdict.
	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		op         <= qpht_pkg::OP_INSERT;
		key        <= '0;
		payload_in <= '0;
		squeeze    <= 1'b0;
		steady     = 1'b0;
		words_sent = 0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		// Wait out the clearing pass before the first register write.
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);

		// Size 0 clamps to 2: fill both slots, then exhaust the probe budget.
		set_table_size(7'd0);
		send_word(qpht_pkg::OP_INSERT, '0, '0);
		send_word(qpht_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(qpht_pkg::OP_INSERT, 31'd5, 32'h1234_5678);
		send_word(qpht_pkg::OP_FIND, 31'h7FFF_FFFF, '0);
		send_word(qpht_pkg::OP_FIND, 31'd9, '0);
		// Delete twice, then a find that hits the deleted slot.
		send_word(qpht_pkg::OP_DELETE, '0, '0);
		send_word(qpht_pkg::OP_DELETE, '0, '0);
		send_word(qpht_pkg::OP_FIND, '0, '0);
		// A deleted slot still blocks an insert.
		send_word(qpht_pkg::OP_INSERT, '0, 32'hCAFE_0001);
		send_word(qpht_pkg::OP_CLEAR, '0, '0);
		send_word(qpht_pkg::OP_FIND, 31'h7FFF_FFFF, '0);

		// Size 127 clamps to 64: repeated key and a probe chain past it.
		set_table_size(7'd127);
		send_word(qpht_pkg::OP_INSERT, 31'd126, 32'hA5A5_0000);
		send_word(qpht_pkg::OP_INSERT, 31'd126, 32'h0000_5A5A);
		send_word(qpht_pkg::OP_INSERT, 31'd63, 32'h0F0F_0F0F);
		send_word(qpht_pkg::OP_FIND, 31'd126, '0);
		send_word(qpht_pkg::OP_DELETE, 31'd126, '0);
		send_word(qpht_pkg::OP_FIND, 31'd126, '0);
		send_word(qpht_pkg::OP_FIND, 31'd63, '0);
		send_word(qpht_pkg::OP_DELETE, 31'd7, '0);

		// Size 1 clamps to 2 over a table that is already full there.
		set_table_size(7'd1);
		send_word(qpht_pkg::OP_INSERT, 31'd3, 32'h8000_0001);
		send_word(qpht_pkg::OP_FIND, 31'd63, '0);

		// Size 65 clamps to 64: alternating bit patterns.
		set_table_size(7'd65);
		send_word(qpht_pkg::OP_CLEAR, '0, '0);
		send_word(qpht_pkg::OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
		send_word(qpht_pkg::OP_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
		send_word(qpht_pkg::OP_FIND, 31'h2AAA_AAAA, '0);

		// Random phases over a spread of sizes.
		random_phase(7'd64, 105);
		random_phase(7'd2, 80);
		random_phase(7'd5, 100);
		random_phase(7'd127, 110);
		random_phase(7'd16, 105);
		random_phase(7'd3, 90);
		random_phase(7'd65, 110);
		random_phase(7'd33, 105);
		random_phase(7'd8, 100);
		random_phase(7'd0, 80);
		random_phase(7'd64, 140);

		// Drain and let the block settle before the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/qpht_pkg.sv
rtl/qpht_dp.sv
rtl/qpht_ctrl.sv
rtl/quadratic_probe_hash_table.sv
tb/hash_table_checker.sv
tb/testbench.sv
